### hw/rtl/cmpr_pkg.sv
// Shared types, constants and helper functions of the CMPR block decoder.
`default_nettype none

package cmpr_pkg;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PIX_PER_BLK = 16;
  localparam int unsigned CNT_W      = $clog2(PIX_PER_BLK);

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  typedef struct packed {
    logic [15:0]      endpoint_first;
    logic [15:0]      endpoint_second;
    logic [31:0]      index_rows;
    logic [POS_W-1:0] corner_x;
    logic [POS_W-1:0] corner_y;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] pixel_x;
    logic [DIM_W-1:0] pixel_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             visible;
    logic             last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [DIM_W-1:0]      wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // One decoded block: palette plus everything needed to place its pixels.
  typedef struct packed {
    rgba_t [3:0]      pal;
    logic [31:0]      idx;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
  } block_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(s/3) for s below 2048: multiply by 683 / 2048.
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cmpr_stream_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface cmpr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cmpr_palette.sv
// Three-stage palette pipeline: endpoint expansion, channel sums, divide by three.
`default_nettype none

module cmpr_palette
  import cmpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          blk_valid,
  input  wire logic     blk_ready,
  output block_t        blk_data
);

  typedef struct packed {
    logic [2:0][7:0]  a;
    logic [2:0][7:0]  b;
    logic             four;
    logic [31:0]      idx;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
  } s1_t;

  typedef struct packed {
    logic [2:0][7:0]  a;
    logic [2:0][7:0]  b;
    logic [2:0][9:0]  s2;
    logic [2:0][9:0]  s3;
    logic [2:0][7:0]  avg;
    logic             four;
    logic [31:0]      idx;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
  } s2_t;

  logic   v1_r, v2_r, v3_r;
  logic   en1, en2, en3;
  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  block_t s3_r, s3_nxt;

  assign en3      = !v3_r || blk_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    s1_nxt.a[2] = widen5(in_data.endpoint_first[15:11]);
    s1_nxt.a[1] = widen6(in_data.endpoint_first[10:5]);
    s1_nxt.a[0] = widen5(in_data.endpoint_first[4:0]);
    s1_nxt.b[2] = widen5(in_data.endpoint_second[15:11]);
    s1_nxt.b[1] = widen6(in_data.endpoint_second[10:5]);
    s1_nxt.b[0] = widen5(in_data.endpoint_second[4:0]);
    s1_nxt.four = in_data.endpoint_first > in_data.endpoint_second;
    s1_nxt.idx  = in_data.index_rows;
    s1_nxt.ox   = in_data.corner_x;
    s1_nxt.oy   = in_data.corner_y;
  end

  always_comb begin
    logic [8:0] pair;
    s2_nxt.a    = s1_r.a;
    s2_nxt.b    = s1_r.b;
    s2_nxt.four = s1_r.four;
    s2_nxt.idx  = s1_r.idx;
    s2_nxt.ox   = s1_r.ox;
    s2_nxt.oy   = s1_r.oy;
    pair        = '0;
    for (int c = 0; c < 3; c++) begin
      s2_nxt.s2[c]  = {1'b0, s1_r.a[c], 1'b0} + {2'b0, s1_r.b[c]};
      s2_nxt.s3[c]  = {2'b0, s1_r.a[c]} + {1'b0, s1_r.b[c], 1'b0};
      pair          = {1'b0, s1_r.a[c]} + {1'b0, s1_r.b[c]};
      s2_nxt.avg[c] = pair[8:1];
    end
  end

  always_comb begin
    logic [2:0][7:0] p2, p3;
    for (int c = 0; c < 3; c++) begin
      p2[c] = s2_r.four ? div3(s2_r.s2[c]) : s2_r.avg[c];
      p3[c] = s2_r.four ? div3(s2_r.s3[c]) : 8'd0;
    end
    s3_nxt.pal[0] = '{r: s2_r.a[2], g: s2_r.a[1], b: s2_r.a[0], a: ALPHA_OPAQUE};
    s3_nxt.pal[1] = '{r: s2_r.b[2], g: s2_r.b[1], b: s2_r.b[0], a: ALPHA_OPAQUE};
    s3_nxt.pal[2] = '{r: p2[2], g: p2[1], b: p2[0], a: ALPHA_OPAQUE};
    s3_nxt.pal[3] = '{r: p3[2], g: p3[1], b: p3[0],
                      a: (s2_r.four ? ALPHA_OPAQUE : ALPHA_CLEAR)};
    s3_nxt.idx    = s2_r.idx;
    s3_nxt.ox     = s2_r.ox;
    s3_nxt.oy     = s2_r.oy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
  end

  assign blk_valid = v3_r;
  assign blk_data  = s3_r;

endmodule

`default_nettype wire

### hw/rtl/cmpr_serializer.sv
// Block holding register and pixel emitter with registered output and clipping.
`default_nettype none

module cmpr_serializer
  import cmpr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire dims_t  dims,
  input  wire logic   blk_valid,
  output logic        blk_ready,
  input  wire block_t blk_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_item_t   out_data
);

  block_t           blk_r;
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;
  logic             adv_out, emit, done, load;
  logic [1:0]       sel;
  rgba_t            col;

  assign adv_out   = !out_valid_r || out_ready;
  assign emit      = busy_r && adv_out;
  assign done      = emit && (cnt_r == CNT_W'(PIX_PER_BLK - 1));
  assign blk_ready = !busy_r || done;
  assign load      = blk_valid && blk_ready;

  // Index bits shift left as pixels go out, so the current one is on top.
  assign sel = blk_r.idx[31:30];
  assign col = blk_r.pal[sel];

  always_comb begin
    out_nxt.pixel_x    = {1'b0, blk_r.ox} + DIM_W'(cnt_r[1:0]);
    out_nxt.pixel_y    = {1'b0, blk_r.oy} + DIM_W'(cnt_r[CNT_W-1:2]);
    out_nxt.red        = col.r;
    out_nxt.green      = col.g;
    out_nxt.blue       = col.b;
    out_nxt.alpha      = col.a;
    out_nxt.visible    = (out_nxt.pixel_x < dims.width) && (out_nxt.pixel_y < dims.height);
    out_nxt.last_pixel = cnt_r == CNT_W'(PIX_PER_BLK - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (adv_out) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (emit) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (done) busy_r <= 1'b0;
      end
    end
    if (emit) out_r <= out_nxt;
    if (load) begin
      blk_r <= blk_data;
    end else if (emit) begin
      blk_r.idx <= {blk_r.idx[29:0], 2'b00};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hw/rtl/cmpr_block_decoder.sv
// Top level of the CMPR block decoder: config registers, palette pipeline, pixel emitter.
//
// Usage:
//   in_chan  (sink): one request per 8-byte compressed block: two RGB565
//            endpoints, the 32-bit row index word and the block origin.
//   out_chan (source): sixteen pixel requests per block, row 0 first, leftmost
//            pixel first, with position, RGBA, visible and last_pixel.
//   cfg_chan (sink): register writes, always ready; index 0 is image_width,
//            index 1 image_height, other indexes are dropped. Sizes above
//            MAX_IMAGE_DIM are held as MAX_IMAGE_DIM. Write only while idle.
// Path: a request passes the three palette stages, the block register and the output
//   register before its first pixel appears.
// Throughput: the pixel emitter gives one pixel per cycle unless out_chan stalls; the
//   palette pipeline holds up to three more blocks.
// Reset (rst_n low, synchronous): pipeline and emitter empty, sizes at 4096.
// Stall: when out_chan.ready is low the output register holds its pixel, the
//   emitter and the palette stages hold, and in_chan.ready drops once all
//   palette stages are full. Nothing is lost or repeated.
`default_nettype none

module cmpr_block_decoder
  import cmpr_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_DIM = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cmpr_stream_if.sink   in_chan,
  cmpr_stream_if.source out_chan,
  cmpr_stream_if.sink   cfg_chan
);

  dims_t  dims_r;
  logic   blk_valid, blk_ready;
  block_t blk_data;
  logic   cfg_fire;

  // Clip a written size to the supported maximum.
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    return (32'(v) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : v;
  endfunction

  // Configuration writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.width  <= dim_clamp(DIM_W'(4096));
      dims_r.height <= dim_clamp(DIM_W'(4096));
    end else if (cfg_fire) begin
      unique case (cfg_chan.data.addr)
        CFG_IMAGE_WIDTH:  dims_r.width  <= dim_clamp(cfg_chan.data.wdata);
        CFG_IMAGE_HEIGHT: dims_r.height <= dim_clamp(cfg_chan.data.wdata);
        default: ;
      endcase
    end
  end

  // Build the four-entry palette over three stages.
  cmpr_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_chan.data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data)
  );

  // Emit sixteen pixels per block, one per cycle while the output is not stalled.
  cmpr_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims_r),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

  // Stored sizes never exceed the supported maximum.
  a_width_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dims_r.width) <= 32'(MAX_IMAGE_DIM))
    else $error("image width above maximum");

  a_height_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dims_r.height) <= 32'(MAX_IMAGE_DIM))
    else $error("image height above maximum");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the CMPR block decoder: predicted pixels, random blocks and sizes.
`timescale 1ns / 100ps

module tb;
  import cmpr_pkg::*;

  localparam int unsigned DIM_LIMIT     = 4096;
  localparam int unsigned POS_MAX       = (1 << POS_W) - 1;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned PHASE_BLOCKS  = 80;
  localparam int unsigned HOLD_CYCLES   = 160;
  // Leave a wide margin on top of the request-to-first-pixel path.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint unsigned TIMEOUT_NS = 5_000_000;

  // Register indexes the block does not decode; writes there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

  // Predicts the sixteen pixels of every accepted block and checks them in order.
  class cmpr_pixel_model;
    int unsigned width_eff;
    int unsigned height_eff;
    out_item_t   expected_pixels[$];
    int unsigned errors;
    int unsigned blocks_seen;
    int unsigned pixels_checked;
    int unsigned visible_seen;
    int unsigned clear_seen;

    function new();
      width_eff  = DIM_LIMIT;
      height_eff = DIM_LIMIT;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] value);
      int unsigned clamped;
      clamped = (32'(value) > DIM_LIMIT) ? DIM_LIMIT : 32'(value);
      case (addr)
        CFG_IMAGE_WIDTH:  width_eff = clamped;
        CFG_IMAGE_HEIGHT: height_eff = clamped;
        default: ;
      endcase
    endfunction

    function void add_block(in_item_t blk);
      logic [7:0] ep0[3];
      logic [7:0] ep1[3];
      logic [7:0] pal[4][4];
      logic       four_color;
      logic [1:0] sel;
      out_item_t  px;
      int         ch;
      int         k;
      ep0[0] = {blk.endpoint_first[15:11], blk.endpoint_first[15:13]};
      ep0[1] = {blk.endpoint_first[10:5], blk.endpoint_first[10:9]};
      ep0[2] = {blk.endpoint_first[4:0], blk.endpoint_first[4:2]};
      ep1[0] = {blk.endpoint_second[15:11], blk.endpoint_second[15:13]};
      ep1[1] = {blk.endpoint_second[10:5], blk.endpoint_second[10:9]};
      ep1[2] = {blk.endpoint_second[4:0], blk.endpoint_second[4:2]};
      // Equal endpoints fall into the three-color mode.
      four_color = blk.endpoint_first > blk.endpoint_second;
      for (ch = 0; ch < 3; ch++) begin
        pal[0][ch] = ep0[ch];
        pal[1][ch] = ep1[ch];
        if (four_color) begin
          pal[2][ch] = 8'((2 * ep0[ch] + ep1[ch]) / 3);
          pal[3][ch] = 8'((ep0[ch] + 2 * ep1[ch]) / 3);
        end else begin
          pal[2][ch] = 8'((ep0[ch] + ep1[ch]) / 2);
          pal[3][ch] = 8'd0;
        end
      end
      pal[0][3] = ALPHA_OPAQUE;
      pal[1][3] = ALPHA_OPAQUE;
      pal[2][3] = ALPHA_OPAQUE;
      pal[3][3] = four_color ? ALPHA_OPAQUE : ALPHA_CLEAR;
      for (k = 0; k < PIX_PER_BLK; k++) begin
        sel           = blk.index_rows[31 - 2 * k -: 2];
        px.pixel_x    = DIM_W'(blk.corner_x + (k % 4));
        px.pixel_y    = DIM_W'(blk.corner_y + (k / 4));
        px.red        = pal[sel][0];
        px.green      = pal[sel][1];
        px.blue       = pal[sel][2];
        px.alpha      = pal[sel][3];
        // Clipped pixels still come out, only with visible low.
        px.visible    = (32'(px.pixel_x) < width_eff) && (32'(px.pixel_y) < height_eff);
        px.last_pixel = (k == PIX_PER_BLK - 1);
        expected_pixels.push_back(px);
      end
      blocks_seen++;
    endfunction

    function void compare(string field, int unsigned want, int unsigned got, out_item_t ref_px);
      if (want != got)
        report($sformatf("pixel (%0d,%0d) %s: expected %0d, got %0d",
                         ref_px.pixel_x, ref_px.pixel_y, field, want, got));
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d) rgba %0d/%0d/%0d/%0d",
                         got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.alpha));
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (want.visible) visible_seen++;
      if (want.alpha == ALPHA_CLEAR) clear_seen++;
      compare("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x), want);
      compare("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y), want);
      compare("red", 32'(want.red), 32'(got.red), want);
      compare("green", 32'(want.green), 32'(got.green), want);
      compare("blue", 32'(want.blue), 32'(got.blue), want);
      compare("alpha", 32'(want.alpha), 32'(got.alpha), want);
      compare("visible", 32'(want.visible), 32'(got.visible), want);
      compare("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel), want);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cmpr_stream_if #(.payload_t(in_item_t))  in_chan ();
  cmpr_stream_if #(.payload_t(out_item_t)) out_chan ();
  cmpr_stream_if #(.payload_t(cfg_item_t)) cfg_chan ();

  cmpr_pixel_model board = new();

  // Knobs shared between the sender, the receiver and the sequence.
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned hold_seq;
  int unsigned cfg_writes;
  int unsigned size_settings;

  cmpr_block_decoder #(
    .MAX_IMAGE_DIM (DIM_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check every pixel request the receiver takes.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_pixel(out_chan.data);
  end

  // Receiver: random stalls, plus a long hold-off each time the sequence bumps hold_seq.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned seen_seq;
    hold_left      = 0;
    seen_seq       = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Each driving task is entered right after a falling edge and returns at one.

  // Offer one block, with random idle cycles first; hold it until accepted.
  task automatic send_block(input in_item_t blk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= blk;
    do @(posedge clk); while (!in_chan.ready);
    board.add_block(blk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
    cfg_chan.valid      <= 1'b1;
    cfg_chan.data.addr  <= addr;
    cfg_chan.data.wdata <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    board.write_reg(addr, value);
    cfg_writes++;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
    cfg_write(CFG_IMAGE_WIDTH, width);
    cfg_write(CFG_IMAGE_HEIGHT, height);
    size_settings++;
  endtask

  // Hold the sender until every predicted pixel is back, then let the pipe settle.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Pick a coordinate: a third of the time right around the clipping edge.
  function automatic logic [POS_W-1:0] pick_coord(input int unsigned size);
    int unsigned lo;
    int unsigned v;
    if ($urandom_range(2) == 0) begin
      lo = (size > 6) ? size - 6 : 0;
      v  = lo + $urandom_range(7);
      return POS_W'((v > POS_MAX) ? POS_MAX : v);
    end
    return POS_W'($urandom_range(POS_MAX));
  endfunction

  function automatic in_item_t random_block();
    in_item_t blk;
    blk.endpoint_first = 16'($urandom);
    case ($urandom_range(7))
      0:       blk.endpoint_second = blk.endpoint_first;
      1:       blk.endpoint_second = blk.endpoint_first ^ (16'h1 << $urandom_range(15));
      default: blk.endpoint_second = 16'($urandom);
    endcase
    blk.index_rows = $urandom;
    blk.corner_x   = pick_coord(board.width_eff);
    blk.corner_y   = pick_coord(board.height_eff);
    return blk;
  endfunction

  // One stretch of random blocks under one idle setting; optionally a long receiver hold-off.
  task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
                           input bit with_hold);
    int unsigned i;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    for (i = 0; i < PHASE_BLOCKS; i++) begin
      // Keep offering blocks while the receiver is held off, so the input stalls.
      if (with_hold && i == PHASE_BLOCKS / 4)
        hold_seq++;
      send_block(random_block());
    end
    in_chan.valid <= 1'b0;
    wait_drained();
  endtask

  // Directed blocks: both palette modes, equal endpoints, field extremes, edge clipping.
  task automatic run_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // four-color mode, every index used
    send_block('{16'hF800, 16'h001F, 32'hE4E4E4E4, 12'd0, 12'd0});
    // three-color mode with transparent black
    send_block('{16'h001F, 16'hF800, 32'hE4E4E4E4, 12'd4, 12'd0});
    // equal endpoints take the three-color path
    send_block('{16'h07E0, 16'h07E0, 32'h1B1B1B1B, 12'd8, 12'd8});
    send_block('{16'hFFFF, 16'h0000, 32'h00000000, 12'd0, 12'd4092});
    send_block('{16'hFFFF, 16'h0000, 32'hFFFFFFFF, 12'd4092, 12'd4092});
    // largest origin: pixels beyond the image are still sent, not visible
    send_block('{16'h0000, 16'hFFFF, 32'hFFFFFFFF, 12'd4095, 12'd4095});
    send_block('{16'h0000, 16'h0000, 32'hAAAAAAAA, 12'd4094, 12'd0});
    send_block('{16'hFFFF, 16'hFFFF, 32'h55555555, 12'd0, 12'd4094});
    // endpoints one apart around the mode boundary
    send_block('{16'h8000, 16'h7FFF, 32'hE4E4E4E4, 12'd100, 12'd200});
    send_block('{16'h7FFF, 16'h8000, 32'h1B1B1B1B, 12'd2048, 12'd2048});
    send_block('{16'h0001, 16'h0000, 32'hF0F0F0F0, 12'd4093, 12'd1});
    send_block('{16'h0000, 16'h0001, 32'h0F0F0F0F, 12'd1, 12'd4093});
    send_block('{16'hA5A5, 16'h5A5A, 32'hC3C3C3C3, 12'hAAA, 12'h555});
    send_block('{16'h5A5A, 16'hA5A5, 32'h3C3C3C3C, 12'h555, 12'hAAA});
    in_chan.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : sequence_main
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_seq      = 0;
    cfg_writes    = 0;
    size_settings = 1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Reset sizes of 4096 first.
    run_directed();

    // Oversized width acts as the limit; height of one; drop a write to a spare index.
    set_size(13'd8191, 13'd1);
    cfg_write(CFG_SPARE_A, 13'd3);
    run_phase(0, 0, 1'b1);

    // Zero width hides everything; oversized height.
    set_size(13'd0, 13'd5000);
    run_phase(66, 0, 1'b0);

    set_size(13'd1, 13'd4096);
    cfg_write(CFG_SPARE_B, 13'd0);
    run_phase(0, 66, 1'b0);

    set_size(DIM_W'($urandom_range(1, DIM_LIMIT)), DIM_W'($urandom_range(1, DIM_LIMIT)));
    run_phase(32, 32, 1'b0);

    // Full register range, then a second hold-off with no idling.
    set_size(DIM_W'($urandom_range(8191)), DIM_W'($urandom_range(8191)));
    run_phase(0, 0, 1'b1);

    if (board.pending() != 0)
      board.report($sformatf("%0d predicted pixels never arrived", board.pending()));

    $display("Run covered %0d blocks, %0d pixels checked (%0d visible, %0d transparent).",
             board.blocks_seen, board.pixels_checked, board.visible_seen, board.clear_seen);
    $display("Register writes: %0d over %0d size settings; mismatches: %0d.",
             cfg_writes, size_settings, board.errors);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout after %0d ns with %0d pixels outstanding", TIMEOUT_NS, board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
